@@ hdl/svg_pkg.sv @@
// Shared widths and codes for the spatial voice gain block.
// Used by the top level, the pipelined divider and the port checker.
package svg_pkg;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_MASTER_VOLUME = 3'd0;
  localparam logic [2:0] REG_LISTENER_X    = 3'd1;
  localparam logic [2:0] REG_LISTENER_Y    = 3'd2;
  localparam logic [2:0] REG_RIGHT_X       = 3'd3;
  localparam logic [2:0] REG_RIGHT_Y       = 3'd4;

  // Fixed-point units and limits.
  localparam logic [16:0] UNIT_Q16   = 17'd65536;
  localparam logic [15:0] UNIT_Q15   = 16'd32768;
  localparam logic [31:0] NEAR_FLOOR = 32'd66;

  // Datapath widths.
  localparam int DIST_W   = 33;              // floor(sqrt(sum of squares))
  localparam int SUMSQ_W  = 66;              // sum of three 33-bit squares
  localparam int NUM_W    = 55;              // divider dividend
  localparam int DEN_W    = 50;              // divider divisor
  localparam int QUO_W    = 16;              // divider quotient bits
  localparam int DIV_LAT  = QUO_W + 1;       // divider register stages

endpackage

@@ hdl/svg_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on svg_pkg for its widths; flags a quotient of 2^16 or more.
module svg_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [svg_pkg::NUM_W-1:0]  num,
  input  logic [svg_pkg::DEN_W-1:0]  den,
  output logic [svg_pkg::QUO_W-1:0]  quo,
  output logic                       ovf
);
  import svg_pkg::*;

  localparam int WIDE_W = DEN_W + QUO_W;

  logic [NUM_W-1:0] rem [0:QUO_W];
  logic [DEN_W-1:0] dv  [0:QUO_W];
  logic [QUO_W-1:0] q   [0:QUO_W];
  logic             ov  [0:QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      q[0]   <= '0;
      ov[0]  <= {{(WIDE_W-NUM_W){1'b0}}, num} >= {den, {QUO_W{1'b0}}};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int B = QUO_W - 1 - k;
    logic [WIDE_W-1:0] trial;
    logic              hit;
    logic [QUO_W-1:0]  qn;

    always_comb begin
      trial = {{QUO_W{1'b0}}, dv[k]} << B;
      hit   = {{(WIDE_W-NUM_W){1'b0}}, rem[k]} >= trial;
      qn    = q[k];
      qn[B] = hit;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= hit ? rem[k] - trial[NUM_W-1:0] : rem[k];
        dv[k+1]  <= dv[k];
        q[k+1]   <= qn;
        ov[k+1]  <= ov[k];
      end
    end
  end

  assign quo = q[QUO_W];
  assign ovf = ov[QUO_W];

endmodule

@@ hdl/spatial_voice_gain.sv @@
// Spatial voice gain: takes one voice word per cycle and returns its left and right
// gains in Q1.15. Throughput is one word per clock while voice_ready is high. On its
// way to gain_valid a word passes the front stages, the 33-stage square root and the
// two 17-stage dividers for attenuation and pan side by side. A two-word output
// buffer lets the pipeline keep taking words while a result waits; voice_ready drops
// only when both buffer slots are full. Registers are at byte addresses 0, 4, 8, 12
// and 16 and should be written only while no word is in flight.
// Depends on svg_pkg and svg_div.
module spatial_voice_gain (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [svg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        voice_valid,
  output logic                        voice_ready,
  input  logic [16:0]                 voice_volume,
  input  logic                        spatial,
  input  logic signed [31:0]          source_x,
  input  logic signed [31:0]          source_y,
  input  logic signed [31:0]          source_z,
  input  logic [31:0]                 near_distance,
  input  logic [31:0]                 far_distance,
  input  logic [15:0]                 rolloff_factor,
  input  logic                        rolloff_inverse,
  output logic                        gain_valid,
  input  logic                        gain_ready,
  output logic [15:0]                 gain_left,
  output logic [15:0]                 gain_right
);
  import svg_pkg::*;

  localparam int TR_W = SUMSQ_W + 1;

  typedef struct packed {
    logic        spatial;
    logic        inverse;
    logic [31:0] near;
    logic [31:0] far;
    logic [15:0] rf;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [32:0] base;
    logic        dot_neg;
    logic [49:0] dot2;
  } carry_t;

  typedef struct packed {
    logic        spatial;
    logic        inverse;
    logic        far_out;
    logic        dzero;
    logic        dot_neg;
    logic [32:0] base;
  } side_t;

  // Configuration registers.
  logic [16:0]        master_volume;
  logic signed [31:0] listener_x;
  logic signed [31:0] listener_y;
  logic signed [15:0] listener_right_x;
  logic signed [15:0] listener_right_y;

  logic adv;

  // Pipeline registers.
  logic               a_v, b_v, c_v, e_v, f_v, g_v, h_v, i_v, j_v;
  ctl_t               a_ctl, b_ctl, c_ctl;
  logic [16:0]        a_vol, a_mv;
  logic signed [32:0] a_dx, a_dy;
  logic signed [31:0] a_sz;
  logic [32:0]        b_ax, b_ay, b_az, b_base, c_base;
  logic signed [48:0] b_px, b_py;
  logic [65:0]        c_sx, c_sy, c_sz;
  logic signed [49:0] c_dot;

  logic               sq_v    [0:DIST_W];
  logic [SUMSQ_W-1:0] sq_rem  [0:DIST_W];
  logic [DIST_W-1:0]  sq_root [0:DIST_W];
  carry_t             sq_c    [0:DIST_W];

  carry_t             e_c, f_c, g_c;
  logic [32:0]        e_diff, e_pd, f_pd;
  logic               e_far_out, e_dzero, f_far_out, f_dzero, g_far_out, g_dzero;
  logic [31:0]        e_range, f_range;
  logic [48:0]        f_prod;
  logic [NUM_W-1:0]   g_num_a, g_num_p;
  logic [DEN_W-1:0]   g_den_a, g_den_p;

  logic               dv_v [0:DIV_LAT-1];
  side_t              side [0:DIV_LAT-1];
  logic [QUO_W-1:0]   quo_a, quo_p;
  logic               ovf_a, ovf_p;

  logic [32:0]        h_base;
  logic [15:0]        h_att, h_pl, h_pr, i_pl, i_pr;
  logic [48:0]        i_ba;
  logic [15:0]        j_left, j_right;

  logic               front_valid, skid_valid, front_valid_next, skid_valid_next;
  logic [15:0]        front_left, front_right, skid_left, skid_right;
  logic [15:0]        front_left_next, front_right_next, skid_left_next, skid_right_next;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume    <= UNIT_Q16;
      listener_x       <= '0;
      listener_y       <= '0;
      listener_right_x <= 16'sd16384;
      listener_right_y <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_MASTER_VOLUME: master_volume    <= pwdata[16:0];
        REG_LISTENER_X:    listener_x       <= pwdata;
        REG_LISTENER_Y:    listener_y       <= pwdata;
        REG_RIGHT_X:       listener_right_x <= pwdata[15:0];
        REG_RIGHT_Y:       listener_right_y <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MASTER_VOLUME: prdata = {15'd0, master_volume};
      REG_LISTENER_X:    prdata = listener_x;
      REG_LISTENER_Y:    prdata = listener_y;
      REG_RIGHT_X:       prdata = 32'(listener_right_x);
      REG_RIGHT_Y:       prdata = 32'(listener_right_y);
      default:           prdata = '0;
    endcase
  end

  // The whole pipeline moves whenever the output buffer has a free slot.
  assign adv         = !skid_valid;
  assign voice_ready = adv;

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0;
      e_v <= 1'b0; f_v <= 1'b0; g_v <= 1'b0;
      h_v <= 1'b0; i_v <= 1'b0; j_v <= 1'b0;
      for (int k = 0; k <= DIST_W; k++) sq_v[k] <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) dv_v[k] <= 1'b0;
    end else if (adv) begin
      a_v     <= voice_valid;
      b_v     <= a_v;
      c_v     <= b_v;
      sq_v[0] <= c_v;
      for (int k = 0; k < DIST_W; k++) sq_v[k+1] <= sq_v[k];
      e_v     <= sq_v[DIST_W];
      f_v     <= e_v;
      g_v     <= f_v;
      dv_v[0] <= g_v;
      for (int k = 0; k < DIV_LAT-1; k++) dv_v[k+1] <= dv_v[k];
      h_v     <= dv_v[DIV_LAT-1];
      i_v     <= h_v;
      j_v     <= i_v;
    end
  end

  // ---------------- front end: offsets, squares, dot product ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage A: clamp the inputs and form the offsets from the listener.
      a_ctl.spatial <= spatial;
      a_ctl.inverse <= rolloff_inverse;
      a_ctl.rf      <= rolloff_factor;
      a_ctl.near    <= (near_distance < NEAR_FLOOR) ? NEAR_FLOOR : near_distance;
      if (far_distance < ((near_distance < NEAR_FLOOR) ? NEAR_FLOOR : near_distance)) begin
        a_ctl.far <= (near_distance < NEAR_FLOOR) ? NEAR_FLOOR : near_distance;
      end else begin
        a_ctl.far <= far_distance;
      end
      a_vol <= (voice_volume > UNIT_Q16) ? UNIT_Q16 : voice_volume;
      a_mv  <= (master_volume > UNIT_Q16) ? UNIT_Q16 : master_volume;
      a_dx  <= 33'(source_x) - 33'(listener_x);
      a_dy  <= 33'(source_y) - 33'(listener_y);
      a_sz  <= source_z;

      // Stage B: magnitudes, projections and base volume.
      b_ctl  <= a_ctl;
      b_ax   <= a_dx[32] ? 33'(-a_dx) : 33'(a_dx);
      b_ay   <= a_dy[32] ? 33'(-a_dy) : 33'(a_dy);
      b_az   <= a_sz[31] ? {1'b0, 32'(-a_sz)} : {1'b0, 32'(a_sz)};
      b_px   <= 49'(a_dx) * 49'(listener_right_x);
      b_py   <= 49'(a_dy) * 49'(listener_right_y);
      b_base <= 33'(a_vol) * 33'(a_mv);

      // Stage C: squares and the summed projection.
      c_ctl  <= b_ctl;
      c_base <= b_base;
      c_sx   <= 66'(b_ax) * 66'(b_ax);
      c_sy   <= 66'(b_ay) * 66'(b_ay);
      c_sz   <= 66'(b_az) * 66'(b_az);
      c_dot  <= 50'(b_px) + 50'(b_py);

      // Stage D feeds the square root.
      sq_rem[0]       <= c_sx + c_sy + c_sz;
      sq_root[0]      <= '0;
      sq_c[0].ctl     <= c_ctl;
      sq_c[0].base    <= c_base;
      sq_c[0].dot_neg <= c_dot[49];
      sq_c[0].dot2    <= c_dot[49] ? {49'(-c_dot), 1'b0} : {49'(c_dot), 1'b0};
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  for (genvar k = 0; k < DIST_W; k++) begin : g_sqrt
    localparam int B = DIST_W - 1 - k;
    logic [TR_W-1:0]   trial;
    logic              hit;
    logic [DIST_W-1:0] rn;

    always_comb begin
      trial = ({{(TR_W-DIST_W){1'b0}}, sq_root[k]} << (B + 1))
              | ({{(TR_W-1){1'b0}}, 1'b1} << (2 * B));
      hit   = {1'b0, sq_rem[k]} >= trial;
      rn    = sq_root[k];
      rn[B] = hit;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k+1]  <= hit ? sq_rem[k] - trial[SUMSQ_W-1:0] : sq_rem[k];
        sq_root[k+1] <= rn;
        sq_c[k+1]    <= sq_c[k];
      end
    end
  end

  // ---------------- attenuation operands ----------------
  logic [32:0] root_d, near33, far33, dmax, cdist;
  logic [31:0] span;

  always_comb begin
    root_d = sq_root[DIST_W];
    near33 = {1'b0, sq_c[DIST_W].ctl.near};
    far33  = {1'b0, sq_c[DIST_W].ctl.far};
    dmax   = (root_d > near33) ? root_d : near33;
    if (root_d < near33) begin
      cdist = near33;
    end else if (root_d > far33) begin
      cdist = far33;
    end else begin
      cdist = root_d;
    end
    span = sq_c[DIST_W].ctl.far - sq_c[DIST_W].ctl.near;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage E: distance past the near limit, pan divisor, linear range.
      e_c       <= sq_c[DIST_W];
      e_diff    <= sq_c[DIST_W].ctl.inverse ? dmax - near33 : cdist - near33;
      e_pd      <= sq_c[DIST_W].ctl.inverse ? root_d : cdist;
      e_far_out <= root_d > far33;
      e_dzero   <= root_d == '0;
      e_range   <= (span < NEAR_FLOOR) ? NEAR_FLOOR : span;

      // Stage F: rolloff times distance.
      f_c       <= e_c;
      f_pd      <= e_pd;
      f_far_out <= e_far_out;
      f_dzero   <= e_dzero;
      f_range   <= e_range;
      f_prod    <= 49'(e_c.ctl.rf) * 49'(e_diff);

      // Stage G: dividend and divisor for both dividers.
      g_c       <= f_c;
      g_far_out <= f_far_out;
      g_dzero   <= f_dzero;
      if (f_c.ctl.inverse) begin
        g_num_a <= {f_c.ctl.near, 23'd0};
        g_den_a <= 50'({f_c.ctl.near, 8'd0}) + 50'(f_prod);
      end else begin
        g_num_a <= {f_prod[47:0], 7'd0};
        g_den_a <= 50'(f_range);
      end
      g_num_p <= 55'(f_c.dot2);
      g_den_p <= 50'(f_pd);
    end
  end

  svg_div u_div_att (
    .clk (clk),
    .en  (adv),
    .num (g_num_a),
    .den (g_den_a),
    .quo (quo_a),
    .ovf (ovf_a)
  );

  svg_div u_div_pan (
    .clk (clk),
    .en  (adv),
    .num (g_num_p),
    .den (g_den_p),
    .quo (quo_p),
    .ovf (ovf_p)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].spatial <= g_c.ctl.spatial;
      side[0].inverse <= g_c.ctl.inverse;
      side[0].far_out <= g_far_out;
      side[0].dzero   <= g_dzero;
      side[0].dot_neg <= g_c.dot_neg;
      side[0].base    <= g_c.base;
      for (int k = 0; k < DIV_LAT-1; k++) side[k+1] <= side[k];
    end
  end

  // ---------------- attenuation, pan and final gains ----------------
  side_t       sd;
  logic [15:0] att, qp, pl, pr;

  always_comb begin
    sd = side[DIV_LAT-1];
    if (sd.inverse) begin
      if (sd.far_out) begin
        att = '0;
      end else begin
        att = (ovf_a || quo_a > UNIT_Q15) ? UNIT_Q15 : quo_a;
      end
    end else begin
      att = (ovf_a || quo_a[15]) ? '0 : UNIT_Q15 - quo_a;
    end
    // A source on the listener stays centered.
    if (sd.dzero) begin
      qp = '0;
    end else begin
      qp = (ovf_p || quo_p > UNIT_Q15) ? UNIT_Q15 : quo_p;
    end
    pl = (sd.dot_neg || qp == '0) ? UNIT_Q15 : UNIT_Q15 - qp;
    pr = (!sd.dot_neg || qp == '0) ? UNIT_Q15 : UNIT_Q15 - qp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_base <= sd.base;
      h_att  <= sd.spatial ? att : UNIT_Q15;
      h_pl   <= sd.spatial ? pl : UNIT_Q15;
      h_pr   <= sd.spatial ? pr : UNIT_Q15;

      i_ba   <= 49'(h_base) * 49'(h_att);
      i_pl   <= h_pl;
      i_pr   <= h_pr;

      j_left  <= 16'((65'(i_ba) * 65'(i_pl)) >> 47);
      j_right <= 16'((65'(i_ba) * 65'(i_pr)) >> 47);
    end
  end

  // ---------------- two-word output buffer ----------------
  always_comb begin
    front_valid_next = front_valid;
    front_left_next  = front_left;
    front_right_next = front_right;
    skid_valid_next  = skid_valid;
    skid_left_next   = skid_left;
    skid_right_next  = skid_right;
    if (front_valid && gain_ready) begin
      front_valid_next = skid_valid;
      front_left_next  = skid_left;
      front_right_next = skid_right;
      skid_valid_next  = 1'b0;
    end
    if (adv && j_v) begin
      if (!front_valid_next) begin
        front_valid_next = 1'b1;
        front_left_next  = j_left;
        front_right_next = j_right;
      end else begin
        skid_valid_next = 1'b1;
        skid_left_next  = j_left;
        skid_right_next = j_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
      skid_valid  <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    front_left  <= front_left_next;
    front_right <= front_right_next;
    skid_left   <= skid_left_next;
    skid_right  <= skid_right_next;
  end

  assign gain_valid = front_valid;
  assign gain_left  = front_left;
  assign gain_right = front_right;

endmodule

@@ hdl/svg_checker.sv @@
// Port-level checks for spatial_voice_gain, attached by the bind below.
// Depends on svg_pkg for the Q1.15 unit.
module svg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        pready,
  input logic                        gain_valid,
  input logic                        gain_ready,
  input logic [15:0]                 gain_left,
  input logic [15:0]                 gain_right
);
  import svg_pkg::*;

  // A word that is not taken stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    gain_valid && !gain_ready |=> gain_valid && $stable(gain_left) && $stable(gain_right))
    else $error("gain word changed while stalled");

  // Gains never exceed unity.
  a_range: assert property (@(posedge clk) disable iff (rst)
    gain_valid |-> gain_left <= UNIT_Q15 && gain_right <= UNIT_Q15)
    else $error("gain above unity");

  // Reset empties the output buffer.
  a_reset: assert property (@(posedge clk) rst |=> !gain_valid)
    else $error("gain word present after reset");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind spatial_voice_gain svg_checker u_svg_checker (.*);
